// File: rtl/byte_stuffing_codec_defines.svh
// Assertion macros shared by the checker of the byte stuffing codec.
`ifndef BYTE_STUFFING_CODEC_DEFINES_SVH
`define BYTE_STUFFING_CODEC_DEFINES_SVH

// Checked only while the block is out of reset.
`define BSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define BSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bsc_pkg.sv
// Shared types and constants of the byte stuffing codec.
package bsc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_FLAG   = 2'd1;
    localparam logic [1:0] CFG_ESCAPE = 2'd2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] FLAG_RESET   = 8'd37;
    localparam logic [7:0] ESCAPE_RESET = 8'd42;

    typedef struct packed {
        logic       mode;
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
    } t_cfg;

    // One classified input byte, as the back end needs it.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       lead_flag;
        logic       lead_escape;
        logic       trail_flag;
        logic       has_data;
        logic       err_open;
        logic       err_close;
        logic       frame_last;
    } t_cmd;

endpackage

// File: rtl/byte_stuffing_codec.sv
// Byte stuffing framer and deframer with configurable flag and escape bytes.
// An accepted byte is queued; its results are then registered at the output.
// Throughput: one result per cycle unless the output stalls; an encoded byte
// yields one to four results, so the input rate is set by the back end output.
// Reset (synchronous, active low) empties the queue, clears the escape state and
// loads mode encode, flag 37 and escape 42.
module byte_stuffing_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tuser,   // [0] frame_first
    input  logic       i_s_tlast,   // frame_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic [3:0] o_m_tuser,   // [0] has_data [1] err_open_flag [2] err_close_flag
                                    // [3] run_last
    output logic       o_m_tlast    // frame_end
);

    bsc_pkg::t_cfg r_cfg;
    bsc_pkg::t_cmd front_cmd;
    bsc_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= bsc_pkg::MODE_ENCODE;
            r_cfg.flag_byte   <= bsc_pkg::FLAG_RESET;
            r_cfg.escape_byte <= bsc_pkg::ESCAPE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bsc_pkg::CFG_MODE:   r_cfg.mode        <= i_cfg_data[0];
                bsc_pkg::CFG_FLAG:   r_cfg.flag_byte   <= i_cfg_data;
                bsc_pkg::CFG_ESCAPE: r_cfg.escape_byte <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_first (i_s_tuser),
        .i_last  (i_s_tlast),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    bsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_user  (o_m_tuser),
        .o_last  (o_m_tlast)
    );

endmodule

// File: rtl/bsc_front.sv
// Front end: accepts input bytes, tracks the escape state and classifies each byte.
module bsc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsc_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_byte,
    input  logic          i_first,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output bsc_pkg::t_cmd o_cmd
);

    logic r_pend;
    logic n_pend;
    logic is_flag;
    logic is_esc;
    logic pend;
    logic dec_data;
    logic dec_eopen;
    logic dec_eclose;
    logic fire;
    logic needs_result;

    assign o_ready = !i_full;
    assign fire    = i_valid && o_ready;
    assign is_flag = (i_byte == i_cfg.flag_byte);
    assign is_esc  = (i_byte == i_cfg.escape_byte);
    // A first byte starts fresh, whatever escape was left open.
    assign pend    = r_pend && !i_first;

    always_comb begin
        if (pend) begin
            dec_data   = 1'b1;
            dec_eopen  = 1'b0;
            dec_eclose = 1'b0;
            n_pend     = 1'b0;
        end else begin
            dec_eopen  = !is_flag && i_first;
            dec_eclose = !is_flag && !i_first && i_last;
            dec_data   = !is_esc && !is_flag;
            n_pend     = is_esc && !i_last;
        end
        if (i_cfg.mode == bsc_pkg::MODE_ENCODE) begin
            n_pend = 1'b0;
        end
    end

    always_comb begin
        o_cmd.frame_last = i_last;
        if (i_cfg.mode == bsc_pkg::MODE_ENCODE) begin
            o_cmd.data_byte   = i_byte;
            o_cmd.lead_flag   = i_first;
            o_cmd.lead_escape = is_flag || is_esc;
            o_cmd.trail_flag  = i_last;
            o_cmd.has_data    = 1'b1;
            o_cmd.err_open    = 1'b0;
            o_cmd.err_close   = 1'b0;
            needs_result      = 1'b1;
        end else begin
            o_cmd.data_byte   = dec_data ? i_byte : 8'd0;
            o_cmd.lead_flag   = 1'b0;
            o_cmd.lead_escape = 1'b0;
            o_cmd.trail_flag  = 1'b0;
            o_cmd.has_data    = dec_data;
            o_cmd.err_open    = dec_eopen;
            o_cmd.err_close   = dec_eclose;
            needs_result      = dec_data || dec_eopen || dec_eclose || i_last;
        end
    end

    assign o_push = fire && needs_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (fire) begin
            r_pend <= n_pend;
        end
    end

endmodule

// File: rtl/bsc_queue.sv
// Short command queue between the front end and the back end.
module bsc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bsc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output bsc_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    bsc_pkg::t_cmd                 r_mem [bsc_pkg::QUEUE_DEPTH];
    logic [bsc_pkg::QUEUE_AW-1:0]  r_wr;
    logic [bsc_pkg::QUEUE_AW-1:0]  r_rd;
    logic [bsc_pkg::QUEUE_CW-1:0]  r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == bsc_pkg::QUEUE_CW'(bsc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == bsc_pkg::QUEUE_AW'(bsc_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == bsc_pkg::QUEUE_AW'(bsc_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/bsc_back.sv
// Back end: expands each command into its result bytes into an output register.
module bsc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsc_pkg::t_cfg i_cfg,
    input  bsc_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic [3:0]    o_user,
    output logic          o_last
);

    localparam logic [2:0] PIECE_LEAD_FLAG = 3'b001;
    localparam logic [2:0] PIECE_ESCAPE    = 3'b010;
    localparam logic [2:0] PIECE_DATA      = 3'b100;
    localparam logic [2:0] PIECE_TRAIL     = 3'b000;

    logic [2:0] r_done;
    logic [2:0] piece;
    logic       r_valid;
    logic [7:0] r_byte;
    logic [3:0] r_user;
    logic       r_last;
    logic [7:0] piece_byte;
    logic       piece_data;
    logic       fin;
    logic       emit;

    always_comb begin
        if (i_cmd.lead_flag && !r_done[0]) begin
            piece = PIECE_LEAD_FLAG;
        end else if (i_cmd.lead_escape && !r_done[1]) begin
            piece = PIECE_ESCAPE;
        end else if (!r_done[2]) begin
            piece = PIECE_DATA;
        end else begin
            piece = PIECE_TRAIL;
        end
    end

    always_comb begin
        unique case (piece)
            PIECE_LEAD_FLAG: begin
                piece_byte = i_cfg.flag_byte;
                piece_data = 1'b1;
                fin        = 1'b0;
            end
            PIECE_ESCAPE: begin
                piece_byte = i_cfg.escape_byte;
                piece_data = 1'b1;
                fin        = 1'b0;
            end
            PIECE_DATA: begin
                piece_byte = i_cmd.data_byte;
                piece_data = i_cmd.has_data;
                fin        = !i_cmd.trail_flag;
            end
            default: begin
                piece_byte = i_cfg.flag_byte;
                piece_data = 1'b1;
                fin        = 1'b1;
            end
        endcase
    end

    assign emit    = !i_empty && (!r_valid || i_ready);
    assign o_pop   = emit && fin;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_user  = r_user;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= piece_byte;
            // Error flags travel only with the data piece.
            r_user <= {fin,
                       i_cmd.err_close && (piece == PIECE_DATA),
                       i_cmd.err_open && (piece == PIECE_DATA),
                       piece_data};
            r_last <= fin && i_cmd.frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_done  <= fin ? 3'b000 : (r_done | piece);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/bsc_checker.sv
// Port-level checker of the byte stuffing codec and its bind to the top level.
`include "byte_stuffing_codec_defines.svh"

module bsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [3:0] o_m_tuser,
    input logic       o_m_tlast
);

    `BSC_ASSERT(a_hold_stalled, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")
    `BSC_ASSERT(a_frame_end_final, i_clk, i_rst_n, o_m_tvalid && o_m_tlast |-> o_m_tuser[3], "frame end on a result that is not the final one of its byte")
    `BSC_ASSERT(a_close_err_at_end, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[2] |-> o_m_tlast && o_m_tuser[3], "closing flag error away from frame end")
    `BSC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid right after reset")

endmodule

bind byte_stuffing_codec bsc_checker u_bsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
